FILE: hw/rtl/lsbf_pkg.sv
package lsbf_pkg;

  typedef struct packed {
    logic [7:0] h;
    logic [7:0] s;
    logic [7:0] v;
    logic [7:0] target;
    logic [7:0] speed;
    logic       v_in;
    logic       v_out;
    logic       s_in;
    logic       s_out;
    logic       hue_up;
    logic       hue_down;
    logic       skip;
  } cell_t;

  localparam int CELL_W = $bits(cell_t);

  typedef enum logic [1:0] {
    OP_PAINT,
    OP_FRAME,
    OP_MOVE,
    OP_CLEAR
  } op_t;

  typedef enum logic [2:0] {
    REG_ACTIVE_PIXELS,
    REG_BRUSH_HUE,
    REG_BRUSH_SATURATION,
    REG_BRUSH_VALUE,
    REG_FADE_RATE,
    REG_FADE_FLAGS,
    REG_START_SPEED
  } reg_idx_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_PAINT_RD,
    ST_PAINT_WR,
    ST_FR_RD,
    ST_FR_LOAD,
    ST_FR_START,
    ST_FR_WAIT,
    ST_FR_WR,
    ST_DONE
  } state_t;

  function automatic cell_t paint_cell(cell_t c, logic [7:0] hue, logic [7:0] sat,
                                       logic [7:0] val, logic [7:0] rate, logic [6:0] f);
    cell_t      r;
    logic       up;
    logic       same;
    logic [7:0] dif;
    r = c;
    up = 1'b1;
    same = 1'b0;
    dif = 8'd0;
    r.speed = rate;
    if (!f[0]) r.v = val; else r.target = val;
    if (f[3:2] == 2'b00) r.s = sat; else r.target = sat;
    if (f[5:4] == 2'b00) begin
      r.h = hue;
    end else begin
      r.target = hue;
      if (hue > c.h) begin
        dif = hue - c.h;
        if (dif > 8'd128) up = 1'b0;
      end else if (hue < c.h) begin
        dif = c.h - hue;
        if (dif < 8'd128) up = 1'b0;
      end else begin
        same = 1'b1;
      end
      if (f[5]) up = !up;
      if (!same) begin
        if (up) r.hue_up = 1'b1; else r.hue_down = 1'b1;
      end
    end
    r.v_in = f[0];
    r.v_out = f[1];
    r.s_in = f[2];
    r.s_out = f[3];
    return r;
  endfunction

endpackage

FILE: hw/rtl/lsbf_ram.sv
module lsbf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64,
  parameter int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (rd_en) rd_data <= mem[rd_addr];
  end

endmodule

FILE: hw/rtl/lsbf_rem.sv
module lsbf_rem (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [31:0] dividend,
  input  logic [15:0] divisor,
  output logic        done,
  output logic        rem_zero
);

  logic        busy_r;
  logic        done_r;
  logic [3:0]  cnt_r;
  logic [15:0] rem_r;
  logic [15:0] rem_nxt;
  logic [31:0] shift_r;
  logic [15:0] div_r;

  function automatic logic [15:0] rem_step(logic [15:0] r, logic b, logic [15:0] d);
    logic [16:0] t;
    t = {r, b};
    if (t >= {1'b0, d}) t = t - {1'b0, d};
    return t[15:0];
  endfunction

  assign rem_nxt = rem_step(rem_step(rem_r, shift_r[31], div_r), shift_r[30], div_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 4'd1;
        if (cnt_r == 4'd15) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      shift_r <= dividend;
      div_r <= divisor;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      shift_r <= {shift_r[29:0], 2'b00};
    end
  end

  assign done = done_r;
  assign rem_zero = (rem_r == 16'd0);

endmodule

FILE: hw/rtl/lsbf_fade.sv
module lsbf_fade
  import lsbf_pkg::*;
(
  input  cell_t       cell_i,
  input  logic        ra_zero,
  input  logic        rb_zero,
  output logic [15:0] div_a,
  output logic [15:0] div_b,
  output cell_t       cell_o
);

  localparam logic [1:0] FM_NONE = 2'd0;
  localparam logic [1:0] FM_LO = 2'd1;
  localparam logic [1:0] FM_HI = 2'd2;

  logic        tbl_slow  [256];
  logic        tbl_subnz [256];
  logic [15:0] tbl_da    [256];
  logic [15:0] tbl_db    [256];
  logic [7:0]  tbl_base  [256];
  logic [1:0]  tbl_fm    [256];

  for (genvar g = 0; g < 256; g++) begin : g_tbl
    localparam int G = (g == 0) ? 1 : g;
    localparam int IV = 800 / G;
    localparam int SUB = IV % 10;
    localparam int II = IV / 10;
    localparam int D1 = (II * II * 10 + II * SUB) / ((SUB > 0) ? SUB : 1);
    localparam int A0 = (2 * G - 80) / 8;
    localparam int AP = (A0 < 0) ? 0 : A0;
    localparam int FS = AP % 10;
    localparam int AB = AP / 10 + ((FS >= 5) ? 1 : 0);
    localparam int DF = (FS >= 5) ? (10 / (10 - FS)) : (10 / ((FS > 0) ? FS : 1));
    assign tbl_slow[g] = (IV > 10) ? 1'b1 : 1'b0;
    assign tbl_subnz[g] = (SUB > 0) ? 1'b1 : 1'b0;
    assign tbl_da[g] = (IV > 10) ? 16'(D1) : 16'(DF);
    assign tbl_db[g] = (IV > 10) ? 16'(II) : 16'd1;
    assign tbl_base[g] = 8'(AB);
    assign tbl_fm[g] = (FS >= 5) ? FM_HI : ((FS > 0) ? FM_LO : FM_NONE);
  end

  assign div_a = tbl_da[cell_i.speed];
  assign div_b = tbl_db[cell_i.speed];

  always_comb begin
    cell_t      c;
    logic       run;
    logic       skip1;
    logic [7:0] add;
    c = cell_i;
    run = 1'b0;
    add = 8'd1;
    skip1 = c.skip;
    if (c.speed != 8'd0) begin
      if (tbl_slow[c.speed]) begin
        skip1 = c.skip | (tbl_subnz[c.speed] & ra_zero);
        if (rb_zero) begin
          if (skip1) c.skip = 1'b0; else run = 1'b1;
        end else begin
          c.skip = skip1;
        end
      end else begin
        add = tbl_base[c.speed];
        if (tbl_fm[c.speed] == FM_HI && ra_zero) add = 8'd1;
        else if (tbl_fm[c.speed] == FM_LO && ra_zero) add = tbl_base[c.speed] + 8'd1;
        if (c.skip) c.skip = 1'b0; else run = 1'b1;
      end
    end
    if (run) begin
      if (c.v_in) begin
        if ($signed({2'b00, c.target}) - $signed({2'b00, add}) <= $signed({2'b00, c.v})) begin
          c.v = c.target;
          c.v_in = 1'b0;
        end else begin
          c.v = c.v + add;
        end
      end else if (c.v_out) begin
        if (c.v <= add) begin
          c.v = 8'd0;
          c.v_out = 1'b0;
        end else begin
          c.v = c.v - add;
        end
      end
      if (c.hue_up) begin
        if (c.target == c.h) c.hue_up = 1'b0; else c.h = c.h + 8'd1;
      end else if (c.hue_down) begin
        if (c.target == c.h) c.hue_down = 1'b0; else c.h = c.h - 8'd1;
      end
      if (c.s_in) begin
        if (c.target == c.s) c.s_in = 1'b0; else c.s = c.s + 8'd1;
      end else if (c.s_out) begin
        if (c.target == c.s) c.s_out = 1'b0; else c.s = c.s - 8'd1;
      end
    end
    cell_o = c;
  end

endmodule

FILE: hw/rtl/led_strip_brush_fade_engine.sv
// LED strip brush and fade engine. The canvas lives in a single-port-write RAM of
// MAX_PIXELS entries; after reset, and for every clear op, a sweep writes zeros over all
// MAX_PIXELS entries, one per cycle, while no input beat is taken. A frame op walks the
// active pixels one at a time: each pixel is read and loaded, two remainder units test
// the frame counter against the pixel's fade interval, and the faded pixel is written
// back once its result can enter the output register. Results leave through an output
// register, so one result may wait while the next input beat is accepted.
module led_strip_brush_fade_engine
  import lsbf_pkg::*;
#(
  parameter int MAX_PIXELS = 64,
  parameter int FRACTION_BITS = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_op,
  input  logic [15:0] in_target_position,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [5:0]  out_pixel_index,
  output logic [7:0]  out_pixel_hue,
  output logic [7:0]  out_pixel_saturation,
  output logic [7:0]  out_pixel_brightness,
  output logic [5:0]  out_brush_index,
  output logic        out_last,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  localparam int IDX_W = (MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1;
  localparam int POS_W = IDX_W + FRACTION_BITS;
  localparam int SUM_W = ((POS_W > 16) ? POS_W : 16) + 2;
  localparam int HI_W = SUM_W - FRACTION_BITS;

  state_t state_r, state_nxt;

  logic [6:0]         ap_r;
  logic [7:0]         hue_r, sat_r, val_r, rate_r;
  logic [6:0]         flags_r;
  logic [15:0]        sspeed_r;
  logic [POS_W-1:0]   pos_r;
  logic signed [15:0] speed_r;
  logic               lp_valid_r;
  logic [IDX_W-1:0]   lp_idx_r;
  logic [31:0]        fcnt_r;
  logic [IDX_W-1:0]   idx_r;
  logic               clr_report_r;
  cell_t              cell_r;

  logic               out_valid_r;
  logic [5:0]         out_pix_r, out_bi_r;
  logic [7:0]         out_h_r, out_s_r, out_v_r;
  logic               out_last_r;

  logic [6:0]             n;
  logic [IDX_W-1:0]       n_m1;
  logic [IDX_W-1:0]       pix;
  logic signed [SUM_W-1:0] ni;
  logic [HI_W-1:0]        ni_hi;
  logic [POS_W-1:0]       top_pos;
  logic [POS_W-1:0]       adv_pos;
  logic signed [15:0]     adv_speed;
  logic [IDX_W-1:0]       move_idx;
  logic                   paint_need;
  logic                   in_acc;
  logic                   out_free;
  logic                   last_pix;

  logic               ram_we, ram_re;
  logic [IDX_W-1:0]   ram_waddr, ram_raddr;
  logic [CELL_W-1:0]  ram_wdata, ram_rdata;
  logic               div_start;
  logic               out_load;
  logic               ra_done, rb_done, ra_zero, rb_zero;
  logic [15:0]        div_a, div_b;
  cell_t              faded;

  assign cfg_ready = 1'b1;
  assign in_stall = (state_r != ST_IDLE);
  assign in_acc = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    if (ap_r == 7'd0) n = 7'd1;
    else if (ap_r > 7'(MAX_PIXELS)) n = 7'(MAX_PIXELS);
    else n = ap_r;
  end

  assign n_m1 = IDX_W'(n - 7'd1);
  assign pix = pos_r[POS_W-1:FRACTION_BITS];
  assign last_pix = (idx_r == n_m1);
  assign paint_need = !lp_valid_r || (lp_idx_r != pix);
  assign move_idx = (in_target_position >= 16'(n)) ? n_m1 : IDX_W'(in_target_position);

  assign ni = $signed({{(SUM_W - POS_W){1'b0}}, pos_r}) + SUM_W'(speed_r);
  assign ni_hi = ni[SUM_W-1:FRACTION_BITS];
  assign top_pos = POS_W'(n_m1) << FRACTION_BITS;

  always_comb begin
    adv_pos = ni[POS_W-1:0];
    adv_speed = speed_r;
    if (ni[SUM_W-1]) begin
      if (flags_r[6]) begin
        adv_pos = '0;
        adv_speed = -speed_r;
      end else begin
        adv_pos = top_pos;
      end
    end else if (ni_hi >= HI_W'(n)) begin
      if (flags_r[6]) begin
        adv_pos = top_pos;
        adv_speed = -speed_r;
      end else begin
        adv_pos = '0;
      end
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR: begin
        if (idx_r == IDX_W'(MAX_PIXELS - 1)) state_nxt = clr_report_r ? ST_DONE : ST_IDLE;
      end
      ST_IDLE: begin
        if (in_acc) begin
          case (op_t'(in_op))
            OP_PAINT: state_nxt = paint_need ? ST_PAINT_RD : ST_DONE;
            OP_FRAME: state_nxt = ST_FR_RD;
            OP_MOVE:  state_nxt = ST_DONE;
            OP_CLEAR: state_nxt = ST_CLEAR;
            default:  state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_PAINT_RD: state_nxt = ST_PAINT_WR;
      ST_PAINT_WR: state_nxt = ST_DONE;
      ST_FR_RD:    state_nxt = ST_FR_LOAD;
      ST_FR_LOAD:  state_nxt = ST_FR_START;
      ST_FR_START: state_nxt = ST_FR_WAIT;
      ST_FR_WAIT: begin
        if (ra_done && rb_done) state_nxt = ST_FR_WR;
      end
      ST_FR_WR: begin
        if (out_free) state_nxt = last_pix ? ST_IDLE : ST_FR_RD;
      end
      ST_DONE: begin
        if (out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    ram_we = 1'b0;
    ram_waddr = idx_r;
    ram_wdata = '0;
    ram_re = 1'b0;
    ram_raddr = idx_r;
    div_start = 1'b0;
    out_load = 1'b0;
    case (state_r)
      ST_CLEAR:    ram_we = 1'b1;
      ST_PAINT_RD: ram_re = 1'b1;
      ST_PAINT_WR: begin
        ram_we = 1'b1;
        ram_wdata = paint_cell(cell_t'(ram_rdata), hue_r, sat_r, val_r, rate_r, flags_r);
      end
      ST_FR_RD:    ram_re = 1'b1;
      ST_FR_START: div_start = 1'b1;
      ST_FR_WR: begin
        ram_we = out_free;
        ram_wdata = faded;
        out_load = out_free;
      end
      ST_DONE:     out_load = out_free;
      default:     ram_we = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
      idx_r <= '0;
      clr_report_r <= 1'b0;
      ap_r <= 7'd64;
      hue_r <= '0;
      sat_r <= '0;
      val_r <= '0;
      rate_r <= '0;
      flags_r <= '0;
      sspeed_r <= '0;
      pos_r <= '0;
      speed_r <= '0;
      lp_valid_r <= 1'b0;
      lp_idx_r <= '0;
      fcnt_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_valid) begin
        case (reg_idx_t'(cfg_index))
          REG_ACTIVE_PIXELS:    ap_r <= cfg_data[6:0];
          REG_BRUSH_HUE:        hue_r <= cfg_data[7:0];
          REG_BRUSH_SATURATION: sat_r <= cfg_data[7:0];
          REG_BRUSH_VALUE:      val_r <= cfg_data[7:0];
          REG_FADE_RATE:        rate_r <= cfg_data[7:0];
          REG_FADE_FLAGS:       flags_r <= cfg_data[6:0];
          REG_START_SPEED:      sspeed_r <= cfg_data;
          default:              ap_r <= ap_r;
        endcase
      end
      if (out_load) out_valid_r <= 1'b1;
      else if (!out_stall) out_valid_r <= 1'b0;
      case (state_r)
        ST_CLEAR: idx_r <= idx_r + IDX_W'(1);
        ST_IDLE: begin
          if (in_acc) begin
            case (op_t'(in_op))
              OP_PAINT: begin
                if (paint_need) begin
                  lp_valid_r <= 1'b1;
                  lp_idx_r <= pix;
                end
                idx_r <= pix;
                pos_r <= adv_pos;
                speed_r <= adv_speed;
              end
              OP_FRAME: idx_r <= '0;
              OP_MOVE: begin
                pos_r <= POS_W'(move_idx) << FRACTION_BITS;
                lp_valid_r <= 1'b0;
                speed_r <= sspeed_r;
              end
              OP_CLEAR: begin
                idx_r <= '0;
                clr_report_r <= 1'b1;
              end
              default: idx_r <= idx_r;
            endcase
          end
        end
        ST_FR_WR: begin
          if (out_free) begin
            if (last_pix) fcnt_r <= fcnt_r + 32'd1;
            else idx_r <= idx_r + IDX_W'(1);
          end
        end
        default: idx_r <= idx_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_FR_LOAD) cell_r <= cell_t'(ram_rdata);
    if (out_load) begin
      out_bi_r <= 6'(pix);
      if (state_r == ST_FR_WR) begin
        out_pix_r <= 6'(idx_r);
        out_h_r <= cell_r.h;
        out_s_r <= cell_r.s;
        out_v_r <= cell_r.v;
        out_last_r <= last_pix;
      end else begin
        out_pix_r <= '0;
        out_h_r <= '0;
        out_s_r <= '0;
        out_v_r <= '0;
        out_last_r <= 1'b1;
      end
    end
  end

  lsbf_ram #(
    .WIDTH(CELL_W),
    .DEPTH(MAX_PIXELS),
    .AW(IDX_W)
  ) u_canvas (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_waddr),
    .wr_data (ram_wdata),
    .rd_en   (ram_re),
    .rd_addr (ram_raddr),
    .rd_data (ram_rdata)
  );

  lsbf_fade u_fade (
    .cell_i  (cell_r),
    .ra_zero (ra_zero),
    .rb_zero (rb_zero),
    .div_a   (div_a),
    .div_b   (div_b),
    .cell_o  (faded)
  );

  lsbf_rem u_rem_a (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (fcnt_r),
    .divisor  (div_a),
    .done     (ra_done),
    .rem_zero (ra_zero)
  );

  lsbf_rem u_rem_b (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (fcnt_r),
    .divisor  (div_b),
    .done     (rb_done),
    .rem_zero (rb_zero)
  );

  assign out_valid = out_valid_r;
  assign out_pixel_index = out_pix_r;
  assign out_pixel_hue = out_h_r;
  assign out_pixel_saturation = out_s_r;
  assign out_pixel_brightness = out_v_r;
  assign out_brush_index = out_bi_r;
  assign out_last = out_last_r;

endmodule

FILE: dv/led_strip_brush_fade_engine_tb.sv
`timescale 1ns / 1ps

module led_strip_brush_fade_engine_tb;
  import lsbf_pkg::*;

  localparam int MAXPIX = 64;
  localparam int FRAC = 8;
  localparam int SETTLE = 200;
  localparam int CYCLE_LIMIT = 10000000;

  typedef struct {
    logic [5:0] pix;
    logic [7:0] hue;
    logic [7:0] sat;
    logic [7:0] bri;
    logic [5:0] brush;
    logic       last;
  } strip_beat_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [1:0]  in_op;
  logic [15:0] in_target_position;
  logic        out_valid;
  logic        out_stall;
  logic [5:0]  out_pixel_index;
  logic [7:0]  out_pixel_hue;
  logic [7:0]  out_pixel_saturation;
  logic [7:0]  out_pixel_brightness;
  logic [5:0]  out_brush_index;
  logic        out_last;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [2:0]  cfg_index;
  logic [15:0] cfg_data;

  led_strip_brush_fade_engine DUT (.*);

  // Shadow copy of the engine state and registers.
  cell_t       canvas_m [MAXPIX];
  longint      brush_fix;
  longint      painted_at;
  shortint     brush_speed;
  int unsigned frame_cnt;
  logic [6:0]  active_m;
  logic [7:0]  hue_m;
  logic [7:0]  sat_m;
  logic [7:0]  val_m;
  logic [7:0]  rate_m;
  logic [6:0]  flags_m;
  shortint     start_m;

  strip_beat_t strip_expect_q[$];
  int          errors;
  int          items_sent;
  int          beats_checked;
  int          frames_sent;
  longint      cycles;

  function automatic int unsigned strip_len();
    if (active_m == 0) return 1;
    if (active_m > MAXPIX) return MAXPIX;
    return active_m;
  endfunction

  function automatic cell_t brushed(cell_t c);
    cell_t r;
    logic  up;
    logic  same;
    r = c;
    up = 1'b1;
    same = 1'b0;
    r.speed = rate_m;
    if (!flags_m[0]) r.v = val_m; else r.target = val_m;
    if (flags_m[3:2] == 2'b00) r.s = sat_m; else r.target = sat_m;
    if (flags_m[5:4] == 2'b00) begin
      r.h = hue_m;
    end else begin
      r.target = hue_m;
      if (hue_m > c.h) begin
        if (int'(hue_m) - int'(c.h) > 128) up = 1'b0;
      end else if (hue_m < c.h) begin
        if (int'(c.h) - int'(hue_m) < 128) up = 1'b0;
      end else begin
        same = 1'b1;
      end
      if (flags_m[5]) up = !up;
      if (!same) begin
        if (up) r.hue_up = 1'b1; else r.hue_down = 1'b1;
      end
    end
    r.v_in = flags_m[0];
    r.v_out = flags_m[1];
    r.s_in = flags_m[2];
    r.s_out = flags_m[3];
    return r;
  endfunction

  function automatic cell_t faded(cell_t c, int unsigned cnt);
    cell_t       r;
    int unsigned fs;
    int unsigned ivl;
    int unsigned sub;
    int          step;
    r = c;
    fs = c.speed;
    step = 1;
    if (fs == 0) return r;
    ivl = 800 / fs;
    if (ivl > 10) begin
      sub = ivl % 10;
      ivl = ivl / 10;
      if (sub > 0 && cnt % ((ivl * ivl * 10 + ivl * sub) / sub) == 0) r.skip = 1'b1;
    end else begin
      ivl = 1;
      step = (int'(fs) + (int'(fs) - 80)) / 8;
      sub = int'(step % 10);
      step = step / 10;
      if (sub >= 5) begin
        step++;
        if (cnt % (10 / (10 - sub)) == 0) step = 1;
      end else if (sub > 0) begin
        if (cnt % (10 / sub) == 0) step++;
      end
    end
    if (cnt % ivl != 0) return r;
    if (r.skip) begin
      r.skip = 1'b0;
      return r;
    end
    if (r.v_in) begin
      if (int'(r.target) - step <= int'(r.v)) begin
        r.v = r.target;
        r.v_in = 1'b0;
      end else begin
        r.v = r.v + step[7:0];
      end
    end else if (r.v_out) begin
      if (int'(r.v) <= step) begin
        r.v = 8'd0;
        r.v_out = 1'b0;
      end else begin
        r.v = r.v - step[7:0];
      end
    end
    if (r.hue_up) begin
      if (r.target == r.h) r.hue_up = 1'b0; else r.h = r.h + 8'd1;
    end else if (r.hue_down) begin
      if (r.target == r.h) r.hue_down = 1'b0; else r.h = r.h - 8'd1;
    end
    if (r.s_in) begin
      if (r.target == r.s) r.s_in = 1'b0; else r.s = r.s + 8'd1;
    end else if (r.s_out) begin
      if (r.target == r.s) r.s_out = 1'b0; else r.s = r.s - 8'd1;
    end
    return r;
  endfunction

  task automatic predict_engine_op(op_t op, logic [15:0] tpos);
    int unsigned n;
    longint      pos;
    longint      top;
    longint      nxt;
    strip_beat_t b;
    n = strip_len();
    b = '{pix: 0, hue: 0, sat: 0, bri: 0, brush: 0, last: 1'b1};
    case (op)
      OP_FRAME: begin
        b.brush = 6'((brush_fix >> FRAC) & 63);
        for (int i = 0; i < n; i++) begin
          b.pix = 6'(i);
          b.hue = canvas_m[i].h;
          b.sat = canvas_m[i].s;
          b.bri = canvas_m[i].v;
          b.last = (i == n - 1);
          strip_expect_q.push_back(b);
          canvas_m[i] = faded(canvas_m[i], frame_cnt);
        end
        frame_cnt++;
        return;
      end
      OP_PAINT: begin
        pos = brush_fix >> FRAC;
        top = longint'(n - 1) << FRAC;
        if (pos != painted_at) begin
          painted_at = pos & 16'hFFFF;
          if (pos < MAXPIX) canvas_m[pos] = brushed(canvas_m[pos]);
        end
        nxt = brush_fix + longint'(brush_speed);
        if (nxt < 0) begin
          if (flags_m[6]) begin
            brush_fix = 0;
            brush_speed = -brush_speed;
          end else begin
            brush_fix = top;
          end
        end else if ((nxt >> FRAC) >= n) begin
          if (flags_m[6]) begin
            brush_fix = top;
            brush_speed = -brush_speed;
          end else begin
            brush_fix = 0;
          end
        end else begin
          brush_fix = nxt;
        end
      end
      OP_MOVE: begin
        pos = tpos;
        if (pos >= n) pos = n - 1;
        brush_fix = pos << FRAC;
        painted_at = 16'hFFFF;
        brush_speed = start_m;
      end
      default: begin
        foreach (canvas_m[i]) canvas_m[i] = '0;
      end
    endcase
    b.brush = 6'((brush_fix >> FRAC) & 63);
    strip_expect_q.push_back(b);
  endtask

  task automatic report(string field, int got, int want);
    $display("MISMATCH %s: got %0d, expected %0d (beat %0d)", field, got, want, beats_checked);
    errors++;
  endtask

  task automatic write_reg(reg_idx_t idx, logic [15:0] d);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= d;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_ACTIVE_PIXELS:    active_m = d[6:0];
      REG_BRUSH_HUE:        hue_m = d[7:0];
      REG_BRUSH_SATURATION: sat_m = d[7:0];
      REG_BRUSH_VALUE:      val_m = d[7:0];
      REG_FADE_RATE:        rate_m = d[7:0];
      REG_FADE_FLAGS:       flags_m = d[6:0];
      default:              start_m = d;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic send_item(op_t op, logic [15:0] tpos, int gap);
    @(negedge clk);
    in_valid <= 1'b1;
    in_op <= op;
    in_target_position <= tpos;
    do @(posedge clk); while (in_stall);
    predict_engine_op(op, tpos);
    items_sent++;
    if (op == OP_FRAME) frames_sent++;
    if (gap > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(20, 70);
  endfunction

  task automatic drain();
    if (in_valid) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    wait (strip_expect_q.size() == 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic setup(logic [15:0] act, logic [15:0] h, logic [15:0] s, logic [15:0] v,
                       logic [15:0] rate, logic [15:0] fl, logic [15:0] spd);
    write_reg(REG_ACTIVE_PIXELS, act);
    write_reg(REG_BRUSH_HUE, h);
    write_reg(REG_BRUSH_SATURATION, s);
    write_reg(REG_BRUSH_VALUE, v);
    write_reg(REG_FADE_RATE, rate);
    write_reg(REG_FADE_FLAGS, fl);
    write_reg(REG_START_SPEED, spd);
  endtask

  task automatic test_reset_canvas();
    send_item(OP_FRAME, 16'h0000, 0);
    drain();
  endtask

  task automatic test_paint_and_wrap();
    setup(16'd8, 16'd200, 16'd100, 16'd255, 16'd0, 16'd0, 16'd384);
    send_item(OP_MOVE, 16'd0, 0);
    repeat (7) send_item(OP_PAINT, 16'h0000, 0);
    send_item(OP_FRAME, 16'h0000, 0);
    drain();
  endtask

  task automatic test_bounce_and_fade();
    setup(16'd5, 16'd10, 16'd255, 16'd255, 16'd255, 16'h0075, 16'h8000);
    send_item(OP_MOVE, 16'hFFFF, 1);
    send_item(OP_PAINT, 16'h0000, 0);
    send_item(OP_PAINT, 16'h0000, 0);
    repeat (3) send_item(OP_FRAME, 16'h0000, 0);
    drain();
    setup(16'd0, 16'd255, 16'd0, 16'd0, 16'd1, 16'h007F, 16'h7FFF);
    send_item(OP_MOVE, 16'd3, 0);
    send_item(OP_PAINT, 16'h0000, 0);
    send_item(OP_FRAME, 16'h0000, 0);
    drain();
  endtask

  task automatic test_shrunk_strip_and_clear();
    setup(16'd127, 16'd77, 16'd33, 16'd128, 16'd80, 16'h000A, 16'hFF00);
    send_item(OP_MOVE, 16'd60, 0);
    drain();
    write_reg(REG_ACTIVE_PIXELS, 16'd10);
    send_item(OP_PAINT, 16'h0000, 0);
    send_item(OP_PAINT, 16'h0000, 0);
    send_item(OP_FRAME, 16'h0000, 0);
    send_item(OP_CLEAR, 16'h0000, 0);
    send_item(OP_FRAME, 16'h0000, 0);
    drain();
  endtask

  task automatic test_random_strokes();
    logic [15:0] act;
    int          r;
    for (int ph = 0; ph < 10; ph++) begin
      r = $urandom_range(0, 9);
      act = (r == 0) ? 16'd64 : (r == 1) ? 16'($urandom_range(0, 65535))
                                         : 16'($urandom_range(1, 16));
      setup(act, 16'($urandom), 16'($urandom), 16'($urandom),
            ($urandom_range(0, 3) == 0) ? 16'($urandom_range(70, 255)) : 16'($urandom),
            16'($urandom), 16'($urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 700)));
      send_item(OP_MOVE, 16'($urandom_range(0, 1) ? $urandom : $urandom_range(0, 20)), pick_gap());
      for (int k = 0; k < 24; k++) begin
        r = $urandom_range(0, 99);
        if (r < 68) begin
          send_item(OP_PAINT, 16'($urandom), pick_gap());
        end else if (r < 84) begin
          send_item(OP_FRAME, 16'($urandom), pick_gap());
        end else if (r < 96) begin
          send_item(OP_MOVE, 16'($urandom), pick_gap());
        end else begin
          send_item(OP_CLEAR, 16'($urandom), pick_gap());
        end
        if (r == 50) begin
          drain();
          write_reg(REG_BRUSH_HUE, 16'($urandom));
        end
      end
      drain();
    end
  endtask

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    int hold;
    int r;
    out_stall = 1'b0;
    hold = 0;
    forever begin
      @(negedge clk);
      if (hold > 0) begin
        hold--;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 50) begin
          out_stall <= 1'b0;
          hold = $urandom_range(0, 25);
        end else if (r < 95) begin
          out_stall <= 1'b1;
          hold = $urandom_range(0, 3);
        end else begin
          out_stall <= 1'b1;
          hold = $urandom_range(20, 60);
        end
      end
    end
  end

  always @(posedge clk) begin
    strip_beat_t w;
    if (rst_n && out_valid && !out_stall) begin
      if (strip_expect_q.size() == 0) begin
        $display("MISMATCH unexpected result beat for pixel %0d", out_pixel_index);
        errors++;
      end else begin
        w = strip_expect_q.pop_front();
        if (out_pixel_index != w.pix) report("pixel_index", out_pixel_index, w.pix);
        if (out_pixel_hue != w.hue) report("pixel_hue", out_pixel_hue, w.hue);
        if (out_pixel_saturation != w.sat) report("pixel_saturation", out_pixel_saturation, w.sat);
        if (out_pixel_brightness != w.bri) report("pixel_brightness", out_pixel_brightness, w.bri);
        if (out_brush_index != w.brush) report("brush_index", out_brush_index, w.brush);
        if (out_last != w.last) report("last", out_last, w.last);
      end
      beats_checked++;
    end
  end

  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
        $display("Timeout after %0d cycles with %0d beats pending", cycles,
                 strip_expect_q.size());
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_op = OP_PAINT;
    in_target_position = 16'd0;
    cfg_valid = 1'b0;
    cfg_index = REG_ACTIVE_PIXELS;
    cfg_data = 16'd0;
    errors = 0;
    items_sent = 0;
    beats_checked = 0;
    frames_sent = 0;
    foreach (canvas_m[i]) canvas_m[i] = '0;
    brush_fix = 0;
    painted_at = 16'hFFFF;
    brush_speed = 0;
    frame_cnt = 0;
    active_m = 7'd64;
    hue_m = 8'd0;
    sat_m = 8'd0;
    val_m = 8'd0;
    rate_m = 8'd0;
    flags_m = 7'd0;
    start_m = 0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_reset_canvas();
    test_paint_and_wrap();
    test_bounce_and_fade();
    test_shrunk_strip_and_clear();
    test_random_strokes();
    drain();

    $display("Ran %0d ops (%0d frames) and checked %0d result beats in %0d cycles.",
             items_sent, frames_sent, beats_checked, cycles);
    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

FILE: led_strip_brush_fade_engine.f
hw/rtl/lsbf_pkg.sv
hw/rtl/lsbf_ram.sv
hw/rtl/lsbf_rem.sv
hw/rtl/lsbf_fade.sv
hw/rtl/led_strip_brush_fade_engine.sv
dv/led_strip_brush_fade_engine_tb.sv
